// File: sv/pvfe_pkg.sv
// Shared types, widths and constants for the polynomial voxel field evaluator.
// No dependencies; every other file uses this package.
package pvfe_pkg;

	localparam int unsigned COEF_COUNT_DEF = 20;
	localparam int unsigned INDEX_BITS_DEF = 10;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam int unsigned VOX_W   = 10;
	localparam int unsigned SIZE_W  = 11;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned ORDER_W = 2;
	localparam int unsigned COEF_W  = 32;
	localparam int unsigned CIDX_W  = 5;
	localparam int unsigned FIELD_W = 48;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Term slots 1..19; slot 0 of the table never enters a sum.
	localparam int unsigned TERM_COUNT = 20;
	localparam int unsigned POS_W  = 28;              // step * centred index, Q.8
	localparam int unsigned CP_W   = COEF_W + POS_W;  // coefficient times position
	localparam int unsigned MON_W  = 2 * POS_W;       // second-order monomial
	localparam int unsigned PROD_W = CP_W + MON_W;
	localparam int unsigned ACC_W  = PROD_W + 5;
	localparam int unsigned GROUPS = TERM_COUNT / 4;
	localparam int unsigned RND_SHIFT = 24;           // Q.40 down to Q.16

	localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(64);
	localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(512);
	localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 3'd0,
		REG_SIZE_Y = 3'd1,
		REG_SIZE_Z = 3'd2,
		REG_STEP_X = 3'd3,
		REG_STEP_Y = 3'd4,
		REG_STEP_Z = 3'd5,
		REG_MODEL  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef enum logic [ORDER_W-1:0] {
		ORDER_ZERO   = 2'd0,
		ORDER_LINEAR = 2'd1,
		ORDER_QUAD   = 2'd2,
		ORDER_CUBIC  = 2'd3
	} order_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [3:0] {
		MON_UNIT = 4'd0,
		MON_X256 = 4'd1,
		MON_Y256 = 4'd2,
		MON_Z256 = 4'd3,
		MON_XX   = 4'd4,
		MON_YY   = 4'd5,
		MON_ZZ   = 4'd6,
		MON_XY   = 4'd7,
		MON_XZ   = 4'd8,
		MON_YZ   = 4'd9
	} mon_kind_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [STEP_W-1:0]  step_x;
		logic [STEP_W-1:0]  step_y;
		logic [STEP_W-1:0]  step_z;
		logic [ORDER_W-1:0] model_order;
	} cfg_t;

	typedef struct packed {
		logic                     is_eval;
		logic [CIDX_W-1:0]        coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic [VOX_W-1:0]         vox_x;
		logic [VOX_W-1:0]         vox_y;
		logic [VOX_W-1:0]         vox_z;
	} q_item_t;

	// Each term is (coef * p) * m: p is one position, m a monomial.
	function automatic axis_t term_axis(input int unsigned k);
		axis_t a;
		unique case (k)
			2, 5, 9, 11, 17, 19: a = AXIS_Y;
			3, 6, 12:            a = AXIS_Z;
			default:             a = AXIS_X;
		endcase
		return a;
	endfunction

	function automatic mon_kind_t term_mon(input int unsigned k);
		mon_kind_t m;
		unique case (k)
			4:           m = MON_X256;
			5, 7:        m = MON_Y256;
			6, 8, 9:     m = MON_Z256;
			10:          m = MON_XX;
			11, 16:      m = MON_YY;
			12, 18, 19:  m = MON_ZZ;
			13:          m = MON_XY;
			14:          m = MON_XZ;
			15, 17:      m = MON_YZ;
			default:     m = MON_UNIT;
		endcase
		return m;
	endfunction

	function automatic order_t term_order(input int unsigned k);
		order_t o;
		if (k >= 10) begin
			o = ORDER_CUBIC;
		end else if (k >= 4) begin
			o = ORDER_QUAD;
		end else begin
			o = ORDER_LINEAR;
		end
		return o;
	endfunction

endpackage

// File: sv/pvfe_cmd_if.sv
// Input channel of the evaluator: valid/ready with load and evaluate fields.
// Depends on pvfe_pkg for field widths.
interface pvfe_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic [pvfe_pkg::CIDX_W-1:0]        coef_index;
	logic signed [pvfe_pkg::COEF_W-1:0] coef_value;
	logic [pvfe_pkg::VOX_W-1:0]         vox_x;
	logic [pvfe_pkg::VOX_W-1:0]         vox_y;
	logic [pvfe_pkg::VOX_W-1:0]         vox_z;

	modport source (output valid, func, coef_index, coef_value, vox_x, vox_y, vox_z,
		input ready);
	modport sink (input valid, func, coef_index, coef_value, vox_x, vox_y, vox_z,
		output ready);
endinterface

// File: sv/pvfe_res_if.sv
// Result channel of the evaluator: valid/ready with the field value.
// Depends on pvfe_pkg for field widths.
interface pvfe_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [pvfe_pkg::FIELD_W-1:0] field_value;
	logic                                saturated;

	modport source (output valid, field_value, saturated, input ready);
	modport sink (input valid, field_value, saturated, output ready);
endinterface

// File: sv/pvfe_cfg_if.sv
// Register write channel of the evaluator: valid/ready, index and data.
// Depends on pvfe_pkg for widths.
interface pvfe_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pvfe_pkg::CFG_IDX_W-1:0]     index;
	logic [pvfe_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pvfe_front.sv
// Front end: takes items off the input channel, drops loads aimed outside the
// table and hands the rest to the queue. Depends on pvfe_pkg, pvfe_cmd_if.
module pvfe_front #(
	parameter int unsigned COEF_COUNT = pvfe_pkg::COEF_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pvfe_cmd_if.sink          cmd,
	input  logic              q_full,
	output logic              push,
	output pvfe_pkg::q_item_t push_item
);
	import pvfe_pkg::*;

	logic    hold_valid_q;
	q_item_t hold_q;
	logic    take;
	logic    keep;

	assign push      = hold_valid_q && !q_full;
	assign push_item = hold_q;
	assign cmd.ready = !hold_valid_q || !q_full;
	assign take      = cmd.valid && cmd.ready;
	// loads beyond the table change nothing: drop them here
	assign keep      = (cmd.func == FUNC_EVAL) ||
		({1'b0, cmd.coef_index} < (CIDX_W + 1)'(COEF_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (take) begin
			hold_valid_q <= keep;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q.is_eval    <= (cmd.func == FUNC_EVAL);
			hold_q.coef_index <= cmd.coef_index;
			hold_q.coef_value <= cmd.coef_value;
			hold_q.vox_x      <= cmd.vox_x;
			hold_q.vox_y      <= cmd.vox_y;
			hold_q.vox_z      <= cmd.vox_z;
		end
	end

endmodule

// File: sv/pvfe_queue.sv
// Short FIFO between front and back end, holding classified items.
// Depends on pvfe_pkg.
module pvfe_queue #(
	parameter int unsigned DEPTH = pvfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pvfe_pkg::q_item_t push_item,
	input  logic              pop,
	output pvfe_pkg::q_item_t head,
	output logic              full,
	output logic              empty
);
	import pvfe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	q_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue popped while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule

// File: sv/pvfe_wmul.sv
// Two-stage signed multiplier for operands wider than one hardware multiplier:
// four partial products, then recombine and restore the sign. Uses pvfe_pkg.
module pvfe_wmul #(
	parameter int unsigned AW = pvfe_pkg::CP_W,
	parameter int unsigned BW = pvfe_pkg::MON_W
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import pvfe_pkg::*;

	localparam int unsigned AL = (AW + 1) / 2;
	localparam int unsigned AH = AW - AL;
	localparam int unsigned BL = (BW + 1) / 2;
	localparam int unsigned BH = BW - BL;

	logic [AW-1:0]     mag_a;
	logic [BW-1:0]     mag_b;
	logic [AL+BL-1:0]  ll_s1;
	logic [AL+BH-1:0]  lh_s1;
	logic [AH+BL-1:0]  hl_s1;
	logic [AH+BH-1:0]  hh_s1;
	logic              neg_s1;
	logic [AW+BW-1:0]  sum;

	assign mag_a = a[AW-1] ? AW'(-a) : AW'(a);
	assign mag_b = b[BW-1] ? BW'(-b) : BW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= (AL + BL)'(mag_a[AL-1:0]) * (AL + BL)'(mag_b[BL-1:0]);
			lh_s1  <= (AL + BH)'(mag_a[AL-1:0]) * (AL + BH)'(mag_b[BW-1:BL]);
			hl_s1  <= (AH + BL)'(mag_a[AW-1:AL]) * (AH + BL)'(mag_b[BL-1:0]);
			hh_s1  <= (AH + BH)'(mag_a[AW-1:AL]) * (AH + BH)'(mag_b[BW-1:BL]);
			neg_s1 <= a[AW-1] ^ b[BW-1];
		end
	end

	assign sum = (AW + BW)'(ll_s1)
		+ ((AW + BW)'(lh_s1) << BL)
		+ ((AW + BW)'(hl_s1) << AL)
		+ ((AW + BW)'(hh_s1) << (AL + BL));

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? $signed(-sum) : $signed(sum);
		end
	end

endmodule

// File: sv/pvfe_back.sv
// Back end: holds the coefficient table, centres and scales voxel indices,
// forms all terms, sums, rounds and saturates. Depends on pvfe_pkg,
// pvfe_wmul and pvfe_res_if.
module pvfe_back #(
	parameter int unsigned COEF_COUNT = pvfe_pkg::COEF_COUNT_DEF,
	parameter int unsigned INDEX_BITS = pvfe_pkg::INDEX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pvfe_pkg::cfg_t    cfg,
	input  pvfe_pkg::q_item_t head,
	input  logic              q_empty,
	output logic              pop,
	pvfe_res_if.source        res
);
	import pvfe_pkg::*;

	localparam logic [VOX_W-1:0] IDX_MASK = (INDEX_BITS >= VOX_W) ? {VOX_W{1'b1}} :
		VOX_W'((1 << INDEX_BITS) - 1);
	localparam logic signed [MON_W-1:0] MON_ONE = MON_W'(65536);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (RND_SHIFT - 1));
	localparam int unsigned SH_W = ACC_W - RND_SHIFT;
	localparam logic signed [SH_W-1:0] F_MAX = SH_W'({1'b0, {(FIELD_W - 1){1'b1}}});
	localparam logic signed [SH_W-1:0] F_MIN =
		SH_W'($signed({1'b1, {(FIELD_W - 1){1'b0}}}));

	function automatic logic signed [POS_W-1:0] pos_of(input logic [VOX_W-1:0] vox,
		input logic [SIZE_W-1:0] sz, input logic [STEP_W-1:0] st);
		logic [SIZE_W-2:0]                half;
		logic [VOX_W-1:0]                 idx;
		logic signed [SIZE_W:0]           diff;
		logic signed [STEP_W+SIZE_W+1:0]  prod;
		half = (sz == '0) ? '0 : (SIZE_W - 1)'((sz - SIZE_W'(1)) >> 1);
		idx  = vox & IDX_MASK;
		diff = $signed((SIZE_W + 1)'(idx)) - $signed((SIZE_W + 1)'(half));
		prod = $signed((STEP_W + SIZE_W + 2)'(st)) * (STEP_W + SIZE_W + 2)'(diff);
		return POS_W'(prod);
	endfunction

	logic adv;
	logic out_valid_q;

	// table
	logic signed [COEF_W-1:0] coef_q [COEF_COUNT];
	logic signed [COEF_W-1:0] coef_rd [1:TERM_COUNT-1];

	// stage registers
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [POS_W-1:0]  px_s1, py_s1, pz_s1;
	logic [ORDER_W-1:0]       model_s1, model_s2;
	logic signed [POS_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [CP_W-1:0]   cp_s2 [1:TERM_COUNT-1];
	logic signed [MON_W-1:0]  xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2;
	logic signed [COEF_W-1:0] off_s1, off_s2, off_s3, off_s4;
	logic signed [PROD_W-1:0] prod_s4 [1:TERM_COUNT-1];
	logic signed [ACC_W-1:0]  terms [TERM_COUNT];
	logic signed [ACC_W-1:0]  grp_s5 [GROUPS];
	logic signed [ACC_W-1:0]  acc_s6;
	logic signed [SH_W-1:0]   shifted;

	assign adv = !out_valid_q || res.ready;
	assign pop = adv && !q_empty;

	// table writes land at the pop edge; an evaluate popped ahead of the load
	// reads in s1 before that edge, so order is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < COEF_COUNT; e++) begin
				coef_q[e] <= '0;
			end
		end else if (pop && !head.is_eval) begin
			for (int e = 0; e < COEF_COUNT; e++) begin
				if ({1'b0, head.coef_index} == (CIDX_W + 1)'(e)) begin
					coef_q[e] <= head.coef_value;
				end
			end
		end
	end

	for (genvar k = 1; k < TERM_COUNT; k++) begin : g_rd
		if (k < COEF_COUNT) begin : g_in
			assign coef_rd[k] = coef_q[k];
		end else begin : g_out
			assign coef_rd[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && head.is_eval;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	// s1: positions
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1    <= pos_of(head.vox_x, cfg.size_x, cfg.step_x);
			py_s1    <= pos_of(head.vox_y, cfg.size_y, cfg.step_y);
			pz_s1    <= pos_of(head.vox_z, cfg.size_z, cfg.step_z);
			model_s1 <= cfg.model_order;
		end
	end

	always_comb begin
		unique case (order_t'(model_s1))
			ORDER_ZERO:   off_s1 = '0;
			ORDER_LINEAR: off_s1 = coef_rd[4];
			default:      off_s1 = coef_rd[10];
		endcase
	end

	// s2: coefficient times position, second-order monomials
	for (genvar k = 1; k < TERM_COUNT; k++) begin : g_cp
		localparam axis_t AX = term_axis(k);
		logic signed [POS_W-1:0] p_sel;
		always_comb begin
			unique case (AX)
				AXIS_Y:  p_sel = py_s1;
				AXIS_Z:  p_sel = pz_s1;
				default: p_sel = px_s1;
			endcase
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cp_s2[k] <= CP_W'(coef_rd[k]) * CP_W'(p_sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s2    <= MON_W'(px_s1) * MON_W'(px_s1);
			yy_s2    <= MON_W'(py_s1) * MON_W'(py_s1);
			zz_s2    <= MON_W'(pz_s1) * MON_W'(pz_s1);
			xy_s2    <= MON_W'(px_s1) * MON_W'(py_s1);
			xz_s2    <= MON_W'(px_s1) * MON_W'(pz_s1);
			yz_s2    <= MON_W'(py_s1) * MON_W'(pz_s1);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			pz_s2    <= pz_s1;
			model_s2 <= model_s1;
			off_s2   <= off_s1;
		end
	end

	// s3, s4: full term products; terms above the model order multiply by zero
	for (genvar k = 1; k < TERM_COUNT; k++) begin : g_term
		localparam mon_kind_t MK = term_mon(k);
		localparam order_t    OK = term_order(k);
		logic signed [MON_W-1:0] m_sel;
		logic signed [MON_W-1:0] m_use;
		always_comb begin
			unique case (MK)
				MON_X256: m_sel = MON_W'(px_s2) <<< 8;
				MON_Y256: m_sel = MON_W'(py_s2) <<< 8;
				MON_Z256: m_sel = MON_W'(pz_s2) <<< 8;
				MON_XX:   m_sel = xx_s2;
				MON_YY:   m_sel = yy_s2;
				MON_ZZ:   m_sel = zz_s2;
				MON_XY:   m_sel = xy_s2;
				MON_XZ:   m_sel = xz_s2;
				MON_YZ:   m_sel = yz_s2;
				default:  m_sel = MON_ONE;
			endcase
		end
		assign m_use = (model_s2 >= OK) ? m_sel : '0;

		pvfe_wmul #(
			.AW(CP_W),
			.BW(MON_W)
		) u_wmul (
			.clk(clk),
			.en (adv),
			.a  (cp_s2[k]),
			.b  (m_use),
			.p  (prod_s4[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s3 <= off_s2;
			off_s4 <= off_s3;
		end
	end

	// s5: partial sums in groups of four
	assign terms[0] = ACC_W'(off_s4) <<< RND_SHIFT;
	for (genvar k = 1; k < TERM_COUNT; k++) begin : g_ext
		assign terms[k] = ACC_W'(prod_s4[k]);
	end

	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		always_ff @(posedge clk) begin
			if (adv) begin
				grp_s5[g] <= terms[4*g] + terms[4*g+1] + terms[4*g+2] + terms[4*g+3];
			end
		end
	end

	// s6: total plus half an output LSB
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s6 <= grp_s5[0] + grp_s5[1] + grp_s5[2] + grp_s5[3] + grp_s5[4] + RND_HALF;
		end
	end

	// output: drop the low 24 fraction bits and clip to 48 bits
	assign shifted = SH_W'(acc_s6 >>> RND_SHIFT);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (shifted > F_MAX) begin
				res.field_value <= FIELD_W'(F_MAX);
				res.saturated   <= 1'b1;
			end else if (shifted < F_MIN) begin
				res.field_value <= FIELD_W'(F_MIN);
				res.saturated   <= 1'b1;
			end else begin
				res.field_value <= FIELD_W'(shifted);
				res.saturated   <= 1'b0;
			end
		end
	end

	assign res.valid = out_valid_q;

endmodule

// File: sv/polynomial_voxel_field_evaluator_unit.sv
// Top level of the polynomial voxel field evaluator: register file, front end,
// queue and back end. Depends on pvfe_pkg, the three channel interfaces,
// pvfe_front, pvfe_queue and pvfe_back.
//
// Usage:
//   cmd carries load items (func 0: write coef_value to table entry coef_index)
//   and evaluate items (func 1: field at voxel vox_x, vox_y, vox_z). Each
//   evaluate item gives exactly one item on res, in order; loads give none and
//   take effect for every evaluate accepted after them.
//   cfg writes the size, step and model order registers; index 7 is ignored.
//   cfg is always ready; write it only while no item is in flight.
// Timing:
//   One item per cycle sustained while res is ready. With no stall an evaluate
//   item passes from the front register, loaded at its acceptance edge,
//   through the queue, six back-end stages and the output register to res.
//   The 116-bit term products run through a two-stage split multiplier, which
//   accounts for two of those back-end stages.
// Stalls and reset:
//   When res is held off the back end freezes; the four-entry queue and the
//   front register keep taking items until they fill, then cmd.ready drops.
//   Reset clears the table to zero, sets sizes 64, steps 2.0 mm, linear model,
//   and empties every stage.
module polynomial_voxel_field_evaluator_unit #(
	parameter int unsigned COEF_COUNT  = pvfe_pkg::COEF_COUNT_DEF,
	parameter int unsigned INDEX_BITS  = pvfe_pkg::INDEX_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = pvfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pvfe_cmd_if.sink   cmd,
	pvfe_res_if.source res,
	pvfe_cfg_if.sink   cfg
);
	import pvfe_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	q_item_t push_item;
	q_item_t head;

	// Register file: always ready, writes beyond the list fall through.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x      <= SIZE_RST;
			cfg_q.size_y      <= SIZE_RST;
			cfg_q.size_z      <= SIZE_RST;
			cfg_q.step_x      <= STEP_RST;
			cfg_q.step_y      <= STEP_RST;
			cfg_q.step_z      <= STEP_RST;
			cfg_q.model_order <= ORDER_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SIZE_X: cfg_q.size_x      <= cfg.data[SIZE_W-1:0];
				REG_SIZE_Y: cfg_q.size_y      <= cfg.data[SIZE_W-1:0];
				REG_SIZE_Z: cfg_q.size_z      <= cfg.data[SIZE_W-1:0];
				REG_STEP_X: cfg_q.step_x      <= cfg.data[STEP_W-1:0];
				REG_STEP_Y: cfg_q.step_y      <= cfg.data[STEP_W-1:0];
				REG_STEP_Z: cfg_q.step_z      <= cfg.data[STEP_W-1:0];
				REG_MODEL:  cfg_q.model_order <= cfg.data[ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accept, classify, hold one item.
	pvfe_front #(
		.COEF_COUNT(COEF_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	// Queue: lets the front keep accepting while the back end is stalled.
	pvfe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: table updates in item order, evaluation pipeline, output register.
	pvfe_back #(
		.COEF_COUNT(COEF_COUNT),
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_empty(q_empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
